// ===== rtl/core/unsa_pkg.sv =====
// ----------------------------------------------------------------------------
// unsa_pkg
// Types and constants shared by the saturating amount adder.
// ----------------------------------------------------------------------------
package unsa_pkg;

    localparam int UNITS_W    = 64;
    localparam int NANOS_W    = 31;
    localparam int CURRENCY_W = 24;

    typedef logic signed [UNITS_W-1:0]   units_t;
    typedef logic signed [NANOS_W-1:0]   nanos_t;
    typedef logic        [CURRENCY_W-1:0] currency_t;
    typedef logic        [1:0]           status_t;

    // billionths sums: pair sum, and after the sign fix-up
    typedef logic signed [NANOS_W:0]     nsum_t;
    typedef logic signed [NANOS_W+1:0]   nfix_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_MISMATCH = 2'd1;
    localparam status_t STATUS_POS_OVF  = 2'd2;
    localparam status_t STATUS_NEG_OVF  = 2'd3;

    localparam nsum_t  BILLION_S    = nsum_t'(1000000000);
    localparam nsum_t  NEG_BILLION  = nsum_t'(-1000000000);
    localparam nfix_t  BILLION_F    = nfix_t'(1000000000);
    localparam nanos_t NANOS_MAX    = nanos_t'(999999999);
    localparam nanos_t NANOS_MIN    = nanos_t'(-999999999);
    localparam units_t UNITS_MAX    = {1'b0, {(UNITS_W-1){1'b1}}};
    localparam units_t UNITS_MIN    = {1'b1, {(UNITS_W-1){1'b0}}};

endpackage

// ===== rtl/core/units_nanos_saturating_add_core.sv =====
// ----------------------------------------------------------------------------
// units_nanos_saturating_add_core
// Saturating sum of two amounts (whole part, billionths, currency code).
// ----------------------------------------------------------------------------
// Four-stage pipeline: one word is accepted every cycle while the output
// is not stalled; the stages are, in order, billionths sum and whole-part
// sum, carry, sign fix-up, saturation select. A stall at the output backs up
// only the stages that are full, so empty stages keep taking words.
module units_nanos_saturating_add_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  unsa_pkg::units_t    a_units,
    input  unsa_pkg::nanos_t    a_nanos,
    input  unsa_pkg::currency_t a_currency,
    input  unsa_pkg::units_t    b_units,
    input  unsa_pkg::nanos_t    b_nanos,
    input  unsa_pkg::currency_t b_currency,
    output logic                out_valid,
    input  logic                out_ready,
    output unsa_pkg::units_t    total_units,
    output unsa_pkg::nanos_t    total_nanos,
    output unsa_pkg::currency_t sum_currency,
    output unsa_pkg::status_t   status
);
    import unsa_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    // stage 1
    nsum_t     nsum1_reg;
    units_t    plain1_reg;
    currency_t cur1_reg;
    logic      match1_reg;
    logic      apos1_reg, aneg1_reg, bpos1_reg, bneg1_reg;
    logic      apos_next, aneg_next, bpos_next, bneg_next;

    // stage 2
    nsum_t     nsum2_reg;
    units_t    usum2_reg;
    logic      pneg2_reg;
    currency_t cur2_reg;
    logic      match2_reg;
    logic      bothpos2_reg, bothneg2_reg;
    nsum_t     nsum2_next;
    units_t    usum2_next;

    // stage 3
    nfix_t     nsum3_reg;
    units_t    usum3_reg;
    logic      pneg3_reg;
    currency_t cur3_reg;
    logic      match3_reg;
    logic      bothpos3_reg, bothneg3_reg;
    nfix_t     nsum3_next;
    units_t    usum3_next;

    // stage 4 (output register)
    units_t    units4_reg, units4_next;
    nanos_t    nanos4_reg, nanos4_next;
    currency_t cur4_reg, cur4_next;
    status_t   status4_reg, status4_next;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage 1: operand signs, billionths sum, whole-part sum
    always_comb
    begin
        apos_next = (a_units != '0 && !a_units[UNITS_W-1])
                    || (a_units == '0 && a_nanos > 0);
        aneg_next = a_units[UNITS_W-1] || (a_units == '0 && a_nanos < 0);
        bpos_next = (b_units != '0 && !b_units[UNITS_W-1])
                    || (b_units == '0 && b_nanos > 0);
        bneg_next = b_units[UNITS_W-1] || (b_units == '0 && b_nanos < 0);
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            nsum1_reg  <= nsum_t'(a_nanos) + nsum_t'(b_nanos);
            plain1_reg <= a_units + b_units;
            cur1_reg   <= a_currency;
            match1_reg <= (a_currency == b_currency);
            apos1_reg  <= apos_next;
            aneg1_reg  <= aneg_next;
            bpos1_reg  <= bpos_next;
            bneg1_reg  <= bneg_next;
        end
    end

    // stage 2: carry out of the billionths into the whole part
    always_comb
    begin
        nsum2_next = nsum1_reg;
        usum2_next = plain1_reg;
        if (nsum1_reg >= BILLION_S)
        begin
            nsum2_next = nsum1_reg - BILLION_S;
            usum2_next = plain1_reg + units_t'(1);
        end
        else if (nsum1_reg <= NEG_BILLION)
        begin
            nsum2_next = nsum1_reg + BILLION_S;
            usum2_next = plain1_reg - units_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            nsum2_reg    <= nsum2_next;
            usum2_reg    <= usum2_next;
            pneg2_reg    <= plain1_reg[UNITS_W-1];
            cur2_reg     <= cur1_reg;
            match2_reg   <= match1_reg;
            bothpos2_reg <= apos1_reg && bpos1_reg;
            bothneg2_reg <= aneg1_reg && bneg1_reg;
        end
    end

    // stage 3: make the signs of whole part and billionths agree
    always_comb
    begin
        nsum3_next = nfix_t'(nsum2_reg);
        usum3_next = usum2_reg;
        if (usum2_reg != '0 && !usum2_reg[UNITS_W-1] && nsum2_reg < 0)
        begin
            usum3_next = usum2_reg - units_t'(1);
            nsum3_next = nfix_t'(nsum2_reg) + BILLION_F;
        end
        else if (usum2_reg[UNITS_W-1] && nsum2_reg > 0)
        begin
            usum3_next = usum2_reg + units_t'(1);
            nsum3_next = nfix_t'(nsum2_reg) - BILLION_F;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            nsum3_reg    <= nsum3_next;
            usum3_reg    <= usum3_next;
            pneg3_reg    <= pneg2_reg;
            cur3_reg     <= cur2_reg;
            match3_reg   <= match2_reg;
            bothpos3_reg <= bothpos2_reg;
            bothneg3_reg <= bothneg2_reg;
        end
    end

    // stage 4: mismatch, saturation, or plain result
    always_comb
    begin
        units4_next  = usum3_reg;
        nanos4_next  = nsum3_reg[NANOS_W-1:0];
        cur4_next    = cur3_reg;
        status4_next = STATUS_OK;
        if (!match3_reg)
        begin
            units4_next  = '0;
            nanos4_next  = '0;
            cur4_next    = '0;
            status4_next = STATUS_MISMATCH;
        end
        else if (bothpos3_reg
                 && (usum3_reg == '0 || usum3_reg[UNITS_W-1]))
        begin
            units4_next  = UNITS_MAX;
            nanos4_next  = NANOS_MAX;
            status4_next = STATUS_POS_OVF;
        end
        else if (bothneg3_reg && (!pneg3_reg || !usum3_reg[UNITS_W-1]))
        begin
            units4_next  = UNITS_MIN;
            nanos4_next  = NANOS_MIN;
            status4_next = STATUS_NEG_OVF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            units4_reg  <= units4_next;
            nanos4_reg  <= nanos4_next;
            cur4_reg    <= cur4_next;
            status4_reg <= status4_next;
        end
    end

    assign out_valid    = v4_reg;
    assign total_units  = units4_reg;
    assign total_nanos  = nanos4_reg;
    assign sum_currency = cur4_reg;
    assign status       = status4_reg;

endmodule

// ===== verif/units_nanos_saturating_add_checker.sv =====
// ----------------------------------------------------------------------------
// units_nanos_saturating_add_checker
// Watches both channels of the saturating amount adder, predicts the sum of
// every accepted word and compares each result word, field by field, with the
// oldest pending prediction. Failures and progress are counted for the top.
// ----------------------------------------------------------------------------
module units_nanos_saturating_add_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  unsa_pkg::units_t    a_units,
    input  unsa_pkg::nanos_t    a_nanos,
    input  unsa_pkg::currency_t a_currency,
    input  unsa_pkg::units_t    b_units,
    input  unsa_pkg::nanos_t    b_nanos,
    input  unsa_pkg::currency_t b_currency,
    input  logic                out_valid,
    input  logic                out_ready,
    input  unsa_pkg::units_t    total_units,
    input  unsa_pkg::nanos_t    total_nanos,
    input  unsa_pkg::currency_t sum_currency,
    input  unsa_pkg::status_t   status,
    output int                  fail_count,
    output int                  pending_sums,
    output int                  sums_checked,
    output int                  sums_saturated,
    output int                  sums_rejected
);
    import unsa_pkg::*;

    localparam longint BILLION = 1000000000;

    typedef struct packed {
        units_t    units;
        nanos_t    nanos;
        currency_t currency;
        status_t   status;
    } sum_word_t;

    sum_word_t pending_q[$];
    sum_word_t want;

    function automatic int amount_sign(input units_t u, input nanos_t n);
        if (u[UNITS_W-1])
            return -1;
        if (u != '0)
            return 1;
        if (n > 0)
            return 1;
        if (n < 0)
            return -1;
        return 0;
    endfunction

    function automatic sum_word_t predict_sum(
        input units_t au, input nanos_t an, input currency_t ac,
        input units_t bu, input nanos_t bn, input currency_t bc);
        sum_word_t   w;
        longint      nsum;
        logic [63:0] carry;
        logic [63:0] plain;
        logic [63:0] usum;
        int          sa;
        int          sb;
        w = '0;
        if (ac != bc)
        begin
            w.status = STATUS_MISMATCH;
            return w;
        end
        nsum  = longint'(an) + longint'(bn);
        carry = '0;
        if (nsum >= BILLION)
        begin
            carry = 64'd1;
            nsum -= BILLION;
        end
        else if (nsum <= -BILLION)
        begin
            carry = '1;
            nsum += BILLION;
        end
        plain = au + bu;
        usum  = plain + carry;
        if (usum != '0 && !usum[63] && nsum < 0)
        begin
            usum -= 64'd1;
            nsum += BILLION;
        end
        else if (usum[63] && nsum > 0)
        begin
            usum += 64'd1;
            nsum -= BILLION;
        end
        sa = amount_sign(au, an);
        sb = amount_sign(bu, bn);
        w.currency = ac;
        if (sa > 0 && sb > 0 && (usum == '0 || usum[63]))
        begin
            w.units  = UNITS_MAX;
            w.nanos  = NANOS_MAX;
            w.status = STATUS_POS_OVF;
        end
        else if (sa < 0 && sb < 0 && (!plain[63] || !usum[63]))
        begin
            w.units  = UNITS_MIN;
            w.nanos  = NANOS_MIN;
            w.status = STATUS_NEG_OVF;
        end
        else
        begin
            w.units  = units_t'(usum);
            w.nanos  = nanos_t'(nsum[NANOS_W-1:0]);
            w.status = STATUS_OK;
        end
        return w;
    endfunction

    initial
    begin
        fail_count     = 0;
        pending_sums   = 0;
        sums_checked   = 0;
        sums_saturated = 0;
        sums_rejected  = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_q.push_back(predict_sum(a_units, a_nanos, a_currency,
                                                b_units, b_nanos, b_currency));
            if (out_valid && out_ready)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("result word with no pending sum: total_units %0d status %0d",
                           total_units, status);
                    fail_count++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    sums_checked++;
                    if (want.status == STATUS_MISMATCH)
                        sums_rejected++;
                    if (want.status == STATUS_POS_OVF || want.status == STATUS_NEG_OVF)
                        sums_saturated++;
                    if (total_units !== want.units)
                    begin
                        $error("total_units: expected %0d, got %0d", want.units,
                               total_units);
                        fail_count++;
                    end
                    if (total_nanos !== want.nanos)
                    begin
                        $error("total_nanos: expected %0d, got %0d", want.nanos,
                               total_nanos);
                        fail_count++;
                    end
                    if (sum_currency !== want.currency)
                    begin
                        $error("sum_currency: expected %h, got %h",
                               want.currency, sum_currency);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                end
            end
            pending_sums = pending_q.size();
        end
    end

endmodule

// ===== verif/units_nanos_saturating_add_core_tb.sv =====
// ----------------------------------------------------------------------------
// units_nanos_saturating_add_core_tb
// Drives the saturating amount adder with directed corner words (extreme
// whole parts, carries, sign fix-up, overflow, code mismatch, out-of-range
// billionths) and then random words under three flow-control phases, with one
// long output hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module units_nanos_saturating_add_core_tb;

    import unsa_pkg::*;

    localparam int        RANDOM_PER_PHASE = 284;
    localparam int        CYCLE_LIMIT      = 200000;
    localparam int        HOLD_CYCLES      = 200;
    localparam currency_t CODE_USD         = 24'h555344;
    localparam currency_t CODE_EUR         = 24'h455552;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    units_t    a_units;
    nanos_t    a_nanos;
    currency_t a_currency;
    units_t    b_units;
    nanos_t    b_nanos;
    currency_t b_currency;
    logic      out_valid;
    logic      out_ready;
    units_t    total_units;
    nanos_t    total_nanos;
    currency_t sum_currency;
    status_t   status;

    int fail_count;
    int pending_sums;
    int sums_checked;
    int sums_saturated;
    int sums_rejected;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int words_sent;
    int words_directed;
    int cycle_count;

    units_nanos_saturating_add_core uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .a_units      (a_units),
        .a_nanos      (a_nanos),
        .a_currency   (a_currency),
        .b_units      (b_units),
        .b_nanos      (b_nanos),
        .b_currency   (b_currency),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .total_units  (total_units),
        .total_nanos  (total_nanos),
        .sum_currency (sum_currency),
        .status       (status)
    );

    units_nanos_saturating_add_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .a_units        (a_units),
        .a_nanos        (a_nanos),
        .a_currency     (a_currency),
        .b_units        (b_units),
        .b_nanos        (b_nanos),
        .b_currency     (b_currency),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .total_units    (total_units),
        .total_nanos    (total_nanos),
        .sum_currency   (sum_currency),
        .status         (status),
        .fail_count     (fail_count),
        .pending_sums   (pending_sums),
        .sums_checked   (sums_checked),
        .sums_saturated (sums_saturated),
        .sums_rejected  (sums_rejected)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d sums pending", cycle_count, pending_sums);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // hold off for a long stretch on request, else stall at random
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input units_t au, input nanos_t an, input currency_t ac,
                             input units_t bu, input nanos_t bn, input currency_t bc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        a_units    <= au;
        a_nanos    <= an;
        a_currency <= ac;
        b_units    <= bu;
        b_nanos    <= bn;
        b_currency <= bc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    function automatic units_t pick_units();
        case ($urandom_range(9))
            0: return UNITS_MAX;
            1: return UNITS_MIN;
            2: return '0;
            3: return units_t'($urandom_range(1000));
            4: return -units_t'($urandom_range(1000));
            5: return UNITS_MAX - units_t'($urandom_range(2));
            6: return UNITS_MIN + units_t'($urandom_range(2));
            7: return units_t'({$urandom, $urandom}) >>> $urandom_range(40);
            default: return units_t'({$urandom, $urandom});
        endcase
    endfunction

    function automatic nanos_t pick_nanos(input units_t u);
        int  mag;
        logic neg;
        if ($urandom_range(9) == 0)
            return nanos_t'($urandom);
        mag = ($urandom_range(3) == 0) ? 999999999 : int'($urandom_range(999999999));
        if (u[UNITS_W-1])
            neg = 1'b1;
        else if (u != '0)
            neg = 1'b0;
        else
            neg = ($urandom_range(1) != 0);
        return neg ? nanos_t'(-mag) : nanos_t'(mag);
    endfunction

    task automatic send_random();
        units_t    au;
        units_t    bu;
        nanos_t    an;
        nanos_t    bn;
        currency_t ac;
        currency_t bc;
        au = pick_units();
        bu = pick_units();
        an = pick_nanos(au);
        bn = pick_nanos(bu);
        ac = ($urandom_range(3) == 0) ? CODE_USD : currency_t'($urandom);
        bc = ac;
        if ($urandom_range(99) < 12)
        begin
            if ($urandom_range(1))
                bc = ac ^ (currency_t'(1) << $urandom_range(CURRENCY_W-1));
            else
                bc = currency_t'($urandom);
        end
        send_word(au, an, ac, bu, bn, bc);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        a_units        = '0;
        a_nanos        = '0;
        a_currency     = '0;
        b_units        = '0;
        b_nanos        = '0;
        b_currency     = '0;
        send_idle_pct  = 29;
        recv_stall_pct = 61;
        hold_req       = 0;
        words_sent     = 0;
        cycle_count    = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word('0, '0, CODE_USD, '0, '0, CODE_USD);
        send_word(UNITS_MAX, NANOS_MAX, CODE_USD, UNITS_MAX, NANOS_MAX, CODE_USD);
        send_word(UNITS_MIN, NANOS_MIN, CODE_EUR, UNITS_MIN, NANOS_MIN, CODE_EUR);
        send_word(64'sd5, 31'sd1, CODE_USD, 64'sd7, 31'sd2, CODE_EUR);
        send_word('0, '0, 24'h000000, '0, '0, 24'hFFFFFF);
        send_word(UNITS_MAX, NANOS_MAX, 24'hFFFFFF, 64'sd3, 31'sd4, 24'hFFFFFF);
        send_word(64'sd1, NANOS_MAX, CODE_USD, 64'sd2, 31'sd1, CODE_USD);
        send_word(-64'sd1, NANOS_MIN, CODE_USD, -64'sd2, -31'sd1, CODE_USD);
        send_word(64'sd3, 31'sd200000000, CODE_USD, -64'sd1, -31'sd500000000, CODE_USD);
        send_word(-64'sd3, -31'sd200000000, CODE_USD, 64'sd1, 31'sd500000000, CODE_USD);
        send_word('0, 31'sd1, CODE_USD, '0, -31'sd1, CODE_USD);
        send_word('0, 31'sd500000000, CODE_USD, '0, 31'sd600000000, CODE_USD);
        send_word(UNITS_MAX, '0, CODE_USD, '0, 31'sd1, CODE_USD);
        send_word(UNITS_MAX, NANOS_MAX, CODE_USD, '0, 31'sd1, CODE_USD);
        send_word(UNITS_MIN, '0, CODE_USD, '0, -31'sd1, CODE_USD);
        send_word(UNITS_MIN, NANOS_MIN, CODE_USD, '0, -31'sd1, CODE_USD);
        send_word(UNITS_MIN, '0, CODE_USD, -64'sd1, '0, CODE_USD);
        send_word(UNITS_MAX, nanos_t'(1073741823), CODE_USD, '0, -31'sd1, CODE_USD);
        send_word('0, nanos_t'(-1073741824), CODE_USD, '0, nanos_t'(-1073741824), CODE_USD);
        send_word('0, nanos_t'(1073741823), CODE_USD, '0, nanos_t'(1073741823), CODE_USD);
        send_word(64'sd5, -31'sd300000000, CODE_EUR, 64'sd2, -31'sd100000000, CODE_EUR);
        send_word('0, '0, CODE_EUR, UNITS_MIN, '0, CODE_EUR);
        words_directed = words_sent;

        repeat (RANDOM_PER_PHASE) send_random();
        send_idle_pct  = 61;
        recv_stall_pct = 29;
        repeat (RANDOM_PER_PHASE) send_random();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        repeat (RANDOM_PER_PHASE) send_random();
        in_valid <= 1'b0;

        while (pending_sums != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("sent %0d words (%0d directed, %0d random) over three idle/stall mixes",
                 words_sent, words_directed, words_sent - words_directed);
        $display("checked %0d sums: %0d saturated, %0d code mismatches, one long hold-off",
                 sums_checked, sums_saturated, sums_rejected);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
